[rtl/core/pid_deadzone_clamped_defines.svh]
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent assertion helpers shared by the PID controller RTL. They expand
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PID_DEADZONE_CLAMPED_DEFINES_SVH
`define PID_DEADZONE_CLAMPED_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PDZ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdz: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PDZ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdz: next-cycle check failed");
`else
`define PDZ_ASSERT_NOW(lbl, ante, cons)
`define PDZ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/core/pdz_pkg.sv]
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register indexes, reset values and transfer payload types.
// ----------------------------------------------------------------------------
package pdz_pkg;

    localparam int ERROR_BITS     = 12;
    localparam int GAIN_FRAC_BITS = 8;

    localparam int GAIN_W  = 16;
    localparam int ACC_W   = 16;
    localparam int ILIM_W  = 15;
    localparam int OLIM_W  = 15;
    localparam int DB_W    = 11;
    localparam int DRIVE_W = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Integral update, dead band compare and derivative widths.
    localparam int ASUM_W = ((ACC_W > ERROR_BITS) ? ACC_W : ERROR_BITS) + 1;
    localparam int CMP_W  = (ERROR_BITS > DB_W) ? ERROR_BITS : DB_W;
    localparam int DER_W  = ERROR_BITS + 1;

    // Product and sum widths.
    localparam int PP_W  = GAIN_W + ERROR_BITS;
    localparam int PI_W  = GAIN_W + ACC_W;
    localparam int PD_W  = GAIN_W + DER_W;
    localparam int SUM_W = ((PI_W > PD_W) ? PI_W : PD_W) + 2;
    localparam int SH_W  = SUM_W - GAIN_FRAC_BITS;

    localparam logic [ILIM_W-1:0] ILIM_RESET = ILIM_W'(100);
    localparam logic [OLIM_W-1:0] OLIM_RESET = OLIM_W'(200);
    localparam logic [DB_W-1:0]   DB_RESET   = DB_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_INTEGRAL_LIMIT = 3'd3,
        CFG_OUTPUT_LIMIT   = 3'd4,
        CFG_DEAD_BAND      = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        FUNC_STEP  = 1'b0,
        FUNC_CLEAR = 1'b1
    } func_t;

    typedef struct packed {
        func_t                        func;
        logic signed [ERROR_BITS-1:0] error_in;
    } sample_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      in_dead_band;
        logic                      saturated;
    } result_t;

endpackage

[rtl/core/pdz_stream_if.sv]
// ----------------------------------------------------------------------------
// PID controller stream interfaces
// Valid/ready channels for error samples and controller results.
// ----------------------------------------------------------------------------
interface pdz_sample_if;
    import pdz_pkg::*;

    logic    valid;
    logic    ready;
    sample_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pdz_result_if;
    import pdz_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/pid_deadzone_clamped.sv]
// ----------------------------------------------------------------------------
// Positional PID controller with dead band and anti-windup
// Fixed-point PID step on a signed error with integral clamp and saturated
// output, as a four-register pipeline that takes one sample per cycle unless stalled.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload                          | handshake
//  --------+-----------+----------------------------------+-------------
//  sample  | in        | func, error_in                   | valid/ready
//  result  | out       | drive, in_dead_band, saturated   | valid/ready
//  cfg     | in        | cfg_index, cfg_data              | cfg_we only
//
// From the input register a sample passes the state update into stage 1, the
// gain multipliers into stage 2 and sum/shift/saturate into the result register.
// One sample is accepted every cycle unless stalled; the integral and previous
// error are updated within the state-update stage, a loop that sets the rate.
// Reset clears the stored state and loads the register reset values.
// A stalled result holds its register; each stage refills as soon as the
// stage after it frees, so samples keep entering until all stages are full.
`include "pid_deadzone_clamped_defines.svh"

module pid_deadzone_clamped (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pdz_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pdz_pkg::CFG_DATA_W-1:0] cfg_data,
    pdz_sample_if.sink                     sample,
    pdz_result_if.source                   result
);
    import pdz_pkg::*;

    // Configuration registers.
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;
    logic [ILIM_W-1:0]        integral_limit_reg;
    logic [OLIM_W-1:0]        output_limit_reg;
    logic [DB_W-1:0]          dead_band_reg;

    // Controller state.
    logic signed [ACC_W-1:0]      accum_reg;
    logic signed [ERROR_BITS-1:0] prev_reg;

    // Pipeline registers.
    logic                         s0_valid_reg;
    sample_t                      s0_data_reg;
    logic                         s1_valid_reg;
    logic                         s1_zero_reg;
    logic                         s1_dz_reg;
    logic signed [ERROR_BITS-1:0] s1_err_reg;
    logic signed [ACC_W-1:0]      s1_acc_reg;
    logic signed [DER_W-1:0]      s1_der_reg;
    logic                         s2_valid_reg;
    logic                         s2_zero_reg;
    logic                         s2_dz_reg;
    logic signed [PP_W-1:0]       s2_pp_reg;
    logic signed [PI_W-1:0]       s2_pi_reg;
    logic signed [PD_W-1:0]       s2_pd_reg;
    logic                         out_valid_reg;
    result_t                      out_data_reg;

    // Flow control: each stage moves when the one after it is free.
    logic out_free;
    logic s2_free;
    logic s2_adv;
    logic s1_free;
    logic s1_adv;
    logic s0_free;
    logic s0_adv;
    logic take;

    // State-update stage signals.
    logic signed [ERROR_BITS-1:0] err;
    logic [ERROR_BITS-1:0]        err_mag;
    logic                         s0_dz;
    logic                         s0_zero;
    logic signed [ASUM_W-1:0]     acc_sum;
    logic signed [ASUM_W-1:0]     acc_lim;
    logic signed [ASUM_W-1:0]     acc_clamped;
    logic signed [ACC_W-1:0]      accum_next;
    logic signed [ERROR_BITS-1:0] prev_next;
    logic signed [DER_W-1:0]      der;

    // Output stage signals.
    logic signed [SUM_W-1:0]   pid_sum;
    logic signed [SH_W-1:0]    pid_shift;
    logic signed [DRIVE_W-1:0] drive_lim;
    logic signed [SH_W-1:0]    out_lim;
    logic signed [SH_W-1:0]    pid_clamped;
    logic                      pid_hit;
    result_t                   out_next;

    assign out_free = !out_valid_reg || result.ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s0_free  = !s0_valid_reg || s1_free;
    assign s0_adv   = s0_valid_reg && s1_free;
    assign take     = sample.valid && s0_free;

    assign sample.ready = s0_free;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // ------------------------------------------------------------------
    // Configuration writes. Unknown indexes are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            integral_limit_reg <= ILIM_RESET;
            output_limit_reg   <= OLIM_RESET;
            dead_band_reg      <= DB_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GAIN_P:         gain_p_reg         <= $signed(cfg_data[GAIN_W-1:0]);
                CFG_GAIN_I:         gain_i_reg         <= $signed(cfg_data[GAIN_W-1:0]);
                CFG_GAIN_D:         gain_d_reg         <= $signed(cfg_data[GAIN_W-1:0]);
                CFG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[ILIM_W-1:0];
                CFG_OUTPUT_LIMIT:   output_limit_reg   <= cfg_data[OLIM_W-1:0];
                CFG_DEAD_BAND:      dead_band_reg      <= cfg_data[DB_W-1:0];
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State update: dead band test, integral clamp and derivative. The
    // magnitude is taken as unsigned so the most negative error is exact.
    // ------------------------------------------------------------------
    always_comb
    begin
        err     = s0_data_reg.error_in;
        err_mag = err[ERROR_BITS-1] ? (~err + ERROR_BITS'(1)) : err;
        s0_dz   = (s0_data_reg.func == FUNC_STEP)
                  && (CMP_W'(err_mag) < CMP_W'(dead_band_reg));
        s0_zero = (s0_data_reg.func == FUNC_CLEAR) || s0_dz;

        acc_sum = ASUM_W'(accum_reg) + ASUM_W'(err);
        acc_lim = ASUM_W'($signed({1'b0, integral_limit_reg}));
        if (acc_sum > acc_lim)
        begin
            acc_clamped = acc_lim;
        end
        else if (acc_sum < -acc_lim)
        begin
            acc_clamped = -acc_lim;
        end
        else
        begin
            acc_clamped = acc_sum;
        end

        der = DER_W'(err) - DER_W'(prev_reg);

        if (s0_zero)
        begin
            accum_next = '0;
            prev_next  = '0;
        end
        else
        begin
            accum_next = ACC_W'(acc_clamped);
            prev_next  = err;
        end
    end

    // ------------------------------------------------------------------
    // Output: floor shift of the gain sum and saturation to the limit.
    // ------------------------------------------------------------------
    always_comb
    begin
        pid_sum   = SUM_W'(s2_pp_reg) + SUM_W'(s2_pi_reg) + SUM_W'(s2_pd_reg);
        pid_shift = SH_W'(pid_sum >>> GAIN_FRAC_BITS);
        drive_lim = DRIVE_W'($signed({1'b0, output_limit_reg}));
        out_lim   = SH_W'(drive_lim);
        pid_hit   = 1'b0;
        if (pid_shift > out_lim)
        begin
            pid_clamped = out_lim;
            pid_hit     = 1'b1;
        end
        else if (pid_shift < -out_lim)
        begin
            pid_clamped = -out_lim;
            pid_hit     = 1'b1;
        end
        else
        begin
            pid_clamped = pid_shift;
        end

        out_next.in_dead_band = s2_dz_reg;
        if (s2_zero_reg)
        begin
            out_next.drive     = '0;
            out_next.saturated = 1'b0;
        end
        else
        begin
            out_next.drive     = DRIVE_W'(pid_clamped);
            out_next.saturated = pid_hit;
        end
    end

    // ------------------------------------------------------------------
    // Control state: valid bits and the controller state.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            accum_reg     <= '0;
            prev_reg      <= '0;
        end
        else
        begin
            if (s0_free)
            begin
                s0_valid_reg <= sample.valid;
            end
            if (s1_free)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (s0_adv)
            begin
                accum_reg <= accum_next;
                prev_reg  <= prev_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers, loaded when their stage takes a new sample.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s0_data_reg <= sample.data;
        end
        if (s0_adv)
        begin
            s1_zero_reg <= s0_zero;
            s1_dz_reg   <= s0_dz;
            s1_err_reg  <= err;
            s1_acc_reg  <= accum_next;
            s1_der_reg  <= der;
        end
        if (s1_adv)
        begin
            s2_zero_reg <= s1_zero_reg;
            s2_dz_reg   <= s1_dz_reg;
            s2_pp_reg   <= PP_W'(gain_p_reg) * PP_W'(s1_err_reg);
            s2_pi_reg   <= PI_W'(gain_i_reg) * PI_W'(s1_acc_reg);
            s2_pd_reg   <= PD_W'(gain_d_reg) * PD_W'(s1_der_reg);
        end
        if (s2_adv)
        begin
            out_data_reg <= out_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `PDZ_ASSERT_NOW(a_free_input, !s0_valid_reg, sample.ready)
    `PDZ_ASSERT_NEXT(a_zero_clears_state, s0_adv && s0_zero,
                     accum_reg == '0 && prev_reg == '0)
    `PDZ_ASSERT_NOW(a_dead_band_zero, result.valid && result.data.in_dead_band,
                    result.data.drive == '0 && !result.data.saturated)
    `PDZ_ASSERT_NOW(a_saturated_at_limit, result.valid && result.data.saturated,
                    result.data.drive == drive_lim || result.data.drive == -drive_lim)

endmodule
